FILE: rtl/core/tqle_pkg.sv
// ----------------------------------------------------------------------------
// tqle_pkg
// Shared types, codes and constants of the tabular Q-learning engine.
// ----------------------------------------------------------------------------
package tqle_pkg;

  typedef enum logic [2:0] {
    FUNC_CHOOSE = 3'd0,
    FUNC_GREEDY = 3'd1,
    FUNC_UPDATE = 3'd2,
    FUNC_READ   = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    CFG_LEARN_RATE    = 3'd0,
    CFG_DISCOUNT      = 3'd1,
    CFG_EXPLORE_START = 3'd2,
    CFG_EXPLORE_DECAY = 3'd3,
    CFG_EXPLORE_FLOOR = 3'd4,
    CFG_RANDOM_SEED   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_DRAW,
    DIV_ACTION,
    DIV_TIE
  } div_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DRAW_EXP,
    ST_WAIT_EXP,
    ST_DRAW_ACT,
    ST_WAIT_ACT,
    ST_RD_S,
    ST_GRAB,
    ST_RD_NS,
    ST_SCAN,
    ST_DRAW_TIE,
    ST_WAIT_TIE,
    ST_PICK,
    ST_MUL_P,
    ST_ADD_T,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD_N,
    ST_RND,
    ST_WR,
    ST_CLR,
    ST_FIN
  } state_e;

  localparam int unsigned     DivW       = 14;
  localparam logic [DivW-1:0] DRAW_RANGE = 14'd10000;
  localparam logic [15:0]     Q_LIMIT    = 16'd32767;

  localparam logic [15:0] LEARN_RATE_RST    = 16'd6554;
  localparam logic [15:0] DISCOUNT_RST      = 16'd58982;
  localparam logic [15:0] EXPLORE_START_RST = 16'd19661;
  localparam logic [15:0] EXPLORE_DECAY_RST = 16'd65470;
  localparam logic [15:0] EXPLORE_FLOOR_RST = 16'd3277;
  localparam logic [31:0] RANDOM_SEED_RST   = 32'd1;

  typedef struct packed {
    logic     load;
    logic     draw;
    div_sel_e div_sel;
    logic     rd_s;
    logic     rd_ns;
    logic     grab;
    logic     scan_clr;
    logic     scan_step;
    logic     pick_step;
    logic     take_rand;
    logic     mul_p;
    logic     add_t;
    logic     mul_lo;
    logic     mul_hi;
    logic     add_n;
    logic     rnd;
    logic     wr;
    logic     clr;
    logic     fin;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  rem_done;
    logic  explore_hit;
    logic  scan_last;
    logic  pick_hit;
  } status_t;

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

FILE: rtl/core/tqle_in_if.sv
// ----------------------------------------------------------------------------
// tqle_in_if
// Request item channel: operation code and operands.
// ----------------------------------------------------------------------------
interface tqle_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic [5:0]        state_index;
  logic [1:0]        action;
  logic signed [15:0] reward_centi;
  logic [5:0]        next_state;

  modport source (output valid, func, state_index, action, reward_centi, next_state,
                  input ready);
  modport sink (input valid, func, state_index, action, reward_centi, next_state,
                output ready);
endinterface

FILE: rtl/core/tqle_out_if.sv
// ----------------------------------------------------------------------------
// tqle_out_if
// Result item channel: chosen action, cell value and engine status.
// ----------------------------------------------------------------------------
interface tqle_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        chosen_action;
  logic              explored;
  logic signed [15:0] q_value;
  logic              saturated;
  logic [15:0]       explore_now;
  logic [31:0]       step_total;

  modport source (output valid, chosen_action, explored, q_value, saturated, explore_now,
                  step_total, input ready);
  modport sink (input valid, chosen_action, explored, q_value, saturated, explore_now,
                step_total, output ready);
endinterface

FILE: rtl/core/tqle_rem.sv
// ----------------------------------------------------------------------------
// tqle_rem
// Iterative remainder of a 32-bit word by a 14-bit divisor, 4 bits per cycle.
// ----------------------------------------------------------------------------
module tqle_rem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [31:0]               dividend_i,
  input  logic [tqle_pkg::DivW-1:0] divisor_i,
  output logic                      done_o,
  output logic [tqle_pkg::DivW-1:0] rem_o
);

  logic [31:0]               num_q;
  logic [tqle_pkg::DivW-1:0] div_q;
  logic [tqle_pkg::DivW-1:0] rem_q, rem_d;
  logic [2:0]                cnt_q;
  logic                      busy_q, done_q;

  always_comb begin
    logic [tqle_pkg::DivW:0] r;
    r = {1'b0, rem_q};
    for (int i = 0; i < 4; i++) begin
      r = {r[tqle_pkg::DivW-1:0], num_q[31-i]};
      if (r >= {1'b0, div_q}) begin
        r = r - {1'b0, div_q};
      end
    end
    rem_d = r[tqle_pkg::DivW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 4;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/core/tqle_dp.sv
// ----------------------------------------------------------------------------
// tqle_dp
// Datapath: configuration, Q table, row scan, update arithmetic, generator.
// ----------------------------------------------------------------------------
module tqle_dp #(
  parameter int unsigned NUM_STATES  = 64,
  parameter int unsigned NUM_ACTIONS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  tqle_pkg::cmd_t     cmd_i,
  output tqle_pkg::status_t  status_o,
  input  logic [2:0]         func_i,
  input  logic [5:0]         state_index_i,
  input  logic [1:0]         action_i,
  input  logic signed [15:0] reward_centi_i,
  input  logic [5:0]         next_state_i,
  output logic [1:0]         chosen_action_o,
  output logic               explored_o,
  output logic signed [15:0] q_value_o,
  output logic               saturated_o,
  output logic [15:0]        explore_now_o,
  output logic [31:0]        step_total_o
);

  localparam int unsigned SW   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int unsigned AW   = $clog2(NUM_ACTIONS);
  localparam int unsigned CW   = $clog2(NUM_ACTIONS + 1);
  localparam int unsigned RowW = NUM_ACTIONS * 16;
  localparam logic signed [52:0] NumLim = $signed(53'(tqle_pkg::Q_LIMIT)) <<< 32;

  logic [15:0] learn_q, discount_q, start_q, decay_q, floor_q;
  logic [31:0] rng_q;
  logic [15:0] rate_q;
  logic [31:0] count_q;

  logic [2:0]         func_q;
  logic [5:0]         st_q, ns_q;
  logic [1:0]         act_q;
  logic signed [15:0] rew_q;

  logic [SW-1:0] s_row, ns_row, rd_addr;
  logic [AW-1:0] a_col;

  logic [RowW-1:0]       mem [NUM_STATES];
  logic [NUM_STATES-1:0] row_valid_q;
  logic [RowW-1:0]       rdata_q, rowbuf_q, new_row;
  logic                  rvalid_q;
  logic [RowW-1:0]       row_m;

  logic [AW-1:0]      scan_q;
  logic [CW-1:0]      tie_q, k_q;
  logic signed [15:0] max_q, cur_cell, q_q;

  logic                      rem_start;
  logic [tqle_pkg::DivW-1:0] divisor, rem_val;
  logic                      rem_done;
  logic [13:0]               thr_q;
  logic [29:0]               thr_prod;

  logic signed [16:0] diff;
  logic signed [32:0] p_q;
  logic signed [34:0] t_q, phi_q;
  logic [32:0]        plo_q;
  logic signed [52:0] num_q;
  logic [52:0]        mag_q;
  logic               sat_hi_q, sat_lo_q, neg_q;
  logic [53:0]        rsum;
  logic [15:0]        rmag, res;
  logic [31:0]        dec_prod;
  logic [15:0]        dec;

  logic [1:0]         chosen_q;
  logic               explored_q, sat_q;
  logic signed [15:0] qv_q;

  assign s_row   = SW'(32'(st_q) % NUM_STATES);
  assign ns_row  = SW'(32'(ns_q) % NUM_STATES);
  assign a_col   = AW'(32'(act_q) % NUM_ACTIONS);
  assign rd_addr = cmd_i.rd_ns ? ns_row : s_row;

  assign row_m    = rvalid_q ? rdata_q : '0;
  assign cur_cell = $signed(row_m[scan_q*16 +: 16]);

  always_comb begin
    case (cmd_i.div_sel)
      tqle_pkg::DIV_DRAW:   divisor = tqle_pkg::DRAW_RANGE;
      tqle_pkg::DIV_ACTION: divisor = tqle_pkg::DivW'(NUM_ACTIONS);
      tqle_pkg::DIV_TIE:    divisor = tqle_pkg::DivW'(tie_q);
      default:              divisor = tqle_pkg::DRAW_RANGE;
    endcase
  end

  assign rem_start = cmd_i.draw;

  tqle_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (tqle_pkg::xorshift(rng_q)),
    .divisor_i  (divisor),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  assign thr_prod = 30'(rate_q) * 30'(tqle_pkg::DRAW_RANGE);

  // update arithmetic: t_q is scaled by 2^16, num_q by 2^32
  assign diff     = $signed({rew_q[15], rew_q}) - $signed({q_q[15], q_q});
  assign rsum     = 54'(mag_q) + 54'(32'h8000_0000);
  assign rmag     = rsum[47:32];
  assign dec_prod = 32'(rate_q) * 32'(decay_q);
  assign dec      = dec_prod[31:16];

  always_comb begin
    if (sat_hi_q) begin
      res = tqle_pkg::Q_LIMIT;
    end else if (sat_lo_q) begin
      res = 16'(-tqle_pkg::Q_LIMIT);
    end else if (neg_q) begin
      res = 16'(-rmag);
    end else begin
      res = rmag;
    end
  end

  always_comb begin
    new_row = rowbuf_q;
    new_row[a_col*16 +: 16] = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_q     <= tqle_pkg::LEARN_RATE_RST;
      discount_q  <= tqle_pkg::DISCOUNT_RST;
      start_q     <= tqle_pkg::EXPLORE_START_RST;
      decay_q     <= tqle_pkg::EXPLORE_DECAY_RST;
      floor_q     <= tqle_pkg::EXPLORE_FLOOR_RST;
      rng_q       <= tqle_pkg::RANDOM_SEED_RST;
      rate_q      <= tqle_pkg::EXPLORE_START_RST;
      count_q     <= '0;
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tqle_pkg::CFG_LEARN_RATE:    learn_q    <= cfg_wdata_i[15:0];
          tqle_pkg::CFG_DISCOUNT:      discount_q <= cfg_wdata_i[15:0];
          tqle_pkg::CFG_EXPLORE_START: start_q    <= cfg_wdata_i[15:0];
          tqle_pkg::CFG_EXPLORE_DECAY: decay_q    <= cfg_wdata_i[15:0];
          tqle_pkg::CFG_EXPLORE_FLOOR: floor_q    <= cfg_wdata_i[15:0];
          tqle_pkg::CFG_RANDOM_SEED:
            rng_q <= (cfg_wdata_i == '0) ? 32'd1 : cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.draw) begin
        rng_q <= tqle_pkg::xorshift(rng_q);
      end
      if (cmd_i.rd_s || cmd_i.rd_ns) begin
        rvalid_q <= row_valid_q[rd_addr];
      end
      if (cmd_i.wr) begin
        row_valid_q[s_row] <= 1'b1;
        count_q            <= count_q + 32'd1;
        rate_q             <= (dec < floor_q) ? floor_q : dec;
      end
      if (cmd_i.clr) begin
        row_valid_q <= '0;
        rate_q      <= start_q;
        count_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_s || cmd_i.rd_ns) begin
      rdata_q <= mem[rd_addr];
    end
    if (cmd_i.wr) begin
      mem[s_row] <= new_row;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q <= thr_prod[29:16];
    if (cmd_i.load) begin
      func_q     <= func_i;
      st_q       <= state_index_i;
      act_q      <= action_i;
      rew_q      <= reward_centi_i;
      ns_q       <= next_state_i;
      chosen_q   <= '0;
      explored_q <= 1'b0;
      qv_q       <= '0;
      sat_q      <= 1'b0;
    end
    if (cmd_i.take_rand) begin
      chosen_q   <= rem_val[1:0];
      explored_q <= 1'b1;
    end
    if (cmd_i.grab) begin
      q_q      <= $signed(row_m[a_col*16 +: 16]);
      qv_q     <= $signed(row_m[a_col*16 +: 16]);
      rowbuf_q <= row_m;
    end
    if (cmd_i.scan_clr) begin
      scan_q <= '0;
      k_q    <= '0;
    end
    if (cmd_i.scan_step) begin
      scan_q <= scan_q + AW'(1);
      if (scan_q == '0 || cur_cell > max_q) begin
        max_q <= cur_cell;
        tie_q <= CW'(1);
      end else if (cur_cell == max_q) begin
        tie_q <= tie_q + CW'(1);
      end
    end
    if (cmd_i.pick_step) begin
      scan_q <= scan_q + AW'(1);
      if (cur_cell == max_q) begin
        k_q <= k_q + CW'(1);
        if (status_o.pick_hit) begin
          chosen_q <= 2'(scan_q);
        end
      end
    end
    if (cmd_i.mul_p) begin
      p_q <= $signed({1'b0, discount_q}) * max_q;
    end
    if (cmd_i.add_t) begin
      t_q <= ($signed(35'(diff)) <<< 16) + 35'(p_q);
    end
    if (cmd_i.mul_lo) begin
      plo_q <= 33'(learn_q) * 33'(t_q[16:0]);
    end
    if (cmd_i.mul_hi) begin
      phi_q <= $signed({1'b0, learn_q}) * $signed(t_q[34:17]);
    end
    if (cmd_i.add_n) begin
      num_q <= ($signed(53'(q_q)) <<< 32) + ($signed(53'(phi_q)) <<< 17)
             + $signed({20'd0, plo_q});
    end
    if (cmd_i.rnd) begin
      sat_hi_q <= num_q > NumLim;
      sat_lo_q <= num_q < -NumLim;
      neg_q    <= num_q[52];
      mag_q    <= num_q[52] ? 53'(-num_q) : 53'(num_q);
    end
    if (cmd_i.wr) begin
      qv_q  <= $signed(res);
      sat_q <= sat_hi_q | sat_lo_q;
    end
    if (cmd_i.fin) begin
      chosen_action_o <= chosen_q;
      explored_o      <= explored_q;
      q_value_o       <= qv_q;
      saturated_o     <= sat_q;
      explore_now_o   <= rate_q;
      step_total_o    <= count_q;
    end
  end

  assign status_o = '{
    func:        tqle_pkg::func_e'(func_q),
    rem_done:    rem_done,
    explore_hit: rem_val < thr_q,
    scan_last:   scan_q == AW'(NUM_ACTIONS - 1),
    pick_hit:    (cur_cell == max_q) && (tqle_pkg::DivW'(k_q) == rem_val)
  };

endmodule

FILE: rtl/core/tqle_ctrl.sv
// ----------------------------------------------------------------------------
// tqle_ctrl
// Controller: sequences each operation and owns the item handshakes.
// ----------------------------------------------------------------------------
module tqle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tqle_pkg::status_t status_i,
  output tqle_pkg::cmd_t    cmd_o
);

  tqle_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             fin_ok;

  assign fin_ok = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tqle_pkg::ST_IDLE: if (in_valid_i) state_d = tqle_pkg::ST_DECODE;
      tqle_pkg::ST_DECODE: begin
        case (status_i.func)
          tqle_pkg::FUNC_CHOOSE: state_d = tqle_pkg::ST_DRAW_EXP;
          tqle_pkg::FUNC_GREEDY: state_d = tqle_pkg::ST_RD_S;
          tqle_pkg::FUNC_UPDATE: state_d = tqle_pkg::ST_RD_S;
          tqle_pkg::FUNC_READ:   state_d = tqle_pkg::ST_RD_S;
          tqle_pkg::FUNC_CLEAR:  state_d = tqle_pkg::ST_CLR;
          default:               state_d = tqle_pkg::ST_FIN;
        endcase
      end
      tqle_pkg::ST_DRAW_EXP: state_d = tqle_pkg::ST_WAIT_EXP;
      tqle_pkg::ST_WAIT_EXP: begin
        if (status_i.rem_done) begin
          state_d = status_i.explore_hit ? tqle_pkg::ST_DRAW_ACT : tqle_pkg::ST_RD_S;
        end
      end
      tqle_pkg::ST_DRAW_ACT: state_d = tqle_pkg::ST_WAIT_ACT;
      tqle_pkg::ST_WAIT_ACT: if (status_i.rem_done) state_d = tqle_pkg::ST_FIN;
      tqle_pkg::ST_RD_S: begin
        if (status_i.func == tqle_pkg::FUNC_UPDATE || status_i.func == tqle_pkg::FUNC_READ) begin
          state_d = tqle_pkg::ST_GRAB;
        end else begin
          state_d = tqle_pkg::ST_SCAN;
        end
      end
      tqle_pkg::ST_GRAB: begin
        state_d = (status_i.func == tqle_pkg::FUNC_READ) ? tqle_pkg::ST_FIN : tqle_pkg::ST_RD_NS;
      end
      tqle_pkg::ST_RD_NS: state_d = tqle_pkg::ST_SCAN;
      tqle_pkg::ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = (status_i.func == tqle_pkg::FUNC_UPDATE) ? tqle_pkg::ST_MUL_P
                                                            : tqle_pkg::ST_DRAW_TIE;
        end
      end
      tqle_pkg::ST_DRAW_TIE: state_d = tqle_pkg::ST_WAIT_TIE;
      tqle_pkg::ST_WAIT_TIE: if (status_i.rem_done) state_d = tqle_pkg::ST_PICK;
      tqle_pkg::ST_PICK:     if (status_i.pick_hit) state_d = tqle_pkg::ST_FIN;
      tqle_pkg::ST_MUL_P:    state_d = tqle_pkg::ST_ADD_T;
      tqle_pkg::ST_ADD_T:    state_d = tqle_pkg::ST_MUL_LO;
      tqle_pkg::ST_MUL_LO:   state_d = tqle_pkg::ST_MUL_HI;
      tqle_pkg::ST_MUL_HI:   state_d = tqle_pkg::ST_ADD_N;
      tqle_pkg::ST_ADD_N:    state_d = tqle_pkg::ST_RND;
      tqle_pkg::ST_RND:      state_d = tqle_pkg::ST_WR;
      tqle_pkg::ST_WR:       state_d = tqle_pkg::ST_FIN;
      tqle_pkg::ST_CLR:      state_d = tqle_pkg::ST_FIN;
      tqle_pkg::ST_FIN:      if (fin_ok) state_d = tqle_pkg::ST_IDLE;
      default:               state_d = tqle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.div_sel = tqle_pkg::DIV_DRAW;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      tqle_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      tqle_pkg::ST_DRAW_EXP: cmd_o.draw = 1'b1;
      tqle_pkg::ST_DRAW_ACT: begin
        cmd_o.draw    = 1'b1;
        cmd_o.div_sel = tqle_pkg::DIV_ACTION;
      end
      tqle_pkg::ST_WAIT_ACT: cmd_o.take_rand = status_i.rem_done;
      tqle_pkg::ST_RD_S: begin
        cmd_o.rd_s     = 1'b1;
        cmd_o.scan_clr = 1'b1;
      end
      tqle_pkg::ST_GRAB: cmd_o.grab = 1'b1;
      tqle_pkg::ST_RD_NS: begin
        cmd_o.rd_ns    = 1'b1;
        cmd_o.scan_clr = 1'b1;
      end
      tqle_pkg::ST_SCAN: cmd_o.scan_step = 1'b1;
      tqle_pkg::ST_DRAW_TIE: begin
        cmd_o.draw     = 1'b1;
        cmd_o.div_sel  = tqle_pkg::DIV_TIE;
        cmd_o.scan_clr = 1'b1;
      end
      tqle_pkg::ST_PICK:   cmd_o.pick_step = 1'b1;
      tqle_pkg::ST_MUL_P:  cmd_o.mul_p = 1'b1;
      tqle_pkg::ST_ADD_T:  cmd_o.add_t = 1'b1;
      tqle_pkg::ST_MUL_LO: cmd_o.mul_lo = 1'b1;
      tqle_pkg::ST_MUL_HI: cmd_o.mul_hi = 1'b1;
      tqle_pkg::ST_ADD_N:  cmd_o.add_n = 1'b1;
      tqle_pkg::ST_RND:    cmd_o.rnd = 1'b1;
      tqle_pkg::ST_WR:     cmd_o.wr = 1'b1;
      tqle_pkg::ST_CLR:    cmd_o.clr = 1'b1;
      tqle_pkg::ST_FIN: begin
        cmd_o.fin = fin_ok;
        if (fin_ok) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tqle_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/tabular_q_learning_engine_unit.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_engine_unit
// Q-table engine with epsilon-greedy choice, greedy pick, update, read, clear.
// ----------------------------------------------------------------------------
// Request items arrive on req_i (valid/ready), one result item per request
// leaves on rsp_o (valid/ready). Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must write it only while the engine is
// idle, which the block does not enforce. Writing the seed also reloads the
// xorshift generator. One item is processed at a time.
// Each random draw runs in the 4-bit-per-cycle remainder unit; row scans
// step through one action per cycle over a registered table row.
// The result register decouples the channels: the next item is accepted
// while a result waits; a stalled receiver holds the engine in its final
// step until the waiting result is taken.
// Reset clears all rows at once through per-row valid bits, loads the
// default configuration and restores the generator to seed 1.
// ----------------------------------------------------------------------------
module tabular_q_learning_engine_unit #(
  parameter int unsigned NUM_STATES  = 64,
  parameter int unsigned NUM_ACTIONS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  tqle_in_if.sink     req_i,
  tqle_out_if.source  rsp_o
);

  tqle_pkg::cmd_t    cmd;
  tqle_pkg::status_t status;
  logic              in_ready;
  logic              out_valid;

  tqle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tqle_dp #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .func_i          (req_i.func),
    .state_index_i   (req_i.state_index),
    .action_i        (req_i.action),
    .reward_centi_i  (req_i.reward_centi),
    .next_state_i    (req_i.next_state),
    .chosen_action_o (rsp_o.chosen_action),
    .explored_o      (rsp_o.explored),
    .q_value_o       (rsp_o.q_value),
    .saturated_o     (rsp_o.saturated),
    .explore_now_o   (rsp_o.explore_now),
    .step_total_o    (rsp_o.step_total)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

endmodule

FILE: bench/tb_tabular_q_learning_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tabular_q_learning_engine_unit
// Self-checking bench for the tabular Q-learning engine.
// ----------------------------------------------------------------------------
// A bit-accurate predictor tracks the Q table, exploration rate, step count
// and xorshift generator. Directed items cover field extremes, every
// operation, ties, saturation, unused codes and zero seed.
// Random phases then run under varied configuration with sender bursts and
// receiver stalls. Each result item is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_tabular_q_learning_engine_unit;

  localparam int unsigned NumStates  = 64;
  localparam int unsigned NumActions = 4;
  localparam int unsigned WatchLimit = 4000;

  typedef struct {
    logic [1:0]         act;
    logic               expl;
    logic signed [15:0] q;
    logic               sat;
    logic [15:0]        rate;
    logic [31:0]        steps;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  tqle_in_if  req ();
  tqle_out_if rsp ();

  tabular_q_learning_engine_unit #(
    .NUM_STATES (NumStates),
    .NUM_ACTIONS(NumActions)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic signed [15:0] q_table [NumStates*NumActions];
  logic [15:0] alpha, gamma, rate_start, rate_decay, rate_floor;
  logic [31:0] rng_word, step_count;
  logic [15:0] rate;

  result_t expected_results[$];
  int errors = 0;
  int checked = 0;
  int sat_seen = 0;
  int explore_seen = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  bit gaps_on = 1'b0;

  initial begin
    req.valid = 1'b0;
    req.func = '0;
    req.state_index = '0;
    req.action = '0;
    req.reward_centi = '0;
    req.next_state = '0;
    rsp.ready = 1'b0;
  end

  function automatic logic [31:0] rng_next();
    logic [31:0] x;
    x = rng_word;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    rng_word = x;
    return x;
  endfunction

  function automatic int row_best(input logic [5:0] s);
    int m;
    m = q_table[{s, 2'd0}];
    for (int a = 1; a < NumActions; a++)
      if (q_table[{s, a[1:0]}] > m) m = q_table[{s, a[1:0]}];
    return m;
  endfunction

  function automatic logic [1:0] greedy_action(input logic [5:0] s);
    int m, n, k;
    logic [1:0] ties [NumActions];
    m = row_best(s);
    n = 0;
    for (int a = 0; a < NumActions; a++)
      if (q_table[{s, a[1:0]}] == m) begin
        ties[n] = a[1:0];
        n++;
      end
    k = rng_next() % n;
    return ties[k];
  endfunction

  function automatic void wipe_table();
    foreach (q_table[i]) q_table[i] = '0;
    rate = rate_start;
    step_count = '0;
  endfunction

  function automatic result_t engine_predict(input logic [2:0] fn, input logic [5:0] s,
                                             input logic [1:0] a, input logic signed [15:0] rw,
                                             input logic [5:0] ns);
    result_t r;
    longint unsigned d, thr, mag;
    longint q, mx, inner, num, lim, res;
    logic [31:0] dec;
    r = '{act: '0, expl: 1'b0, q: '0, sat: 1'b0, rate: '0, steps: '0};
    case (fn)
      tqle_pkg::FUNC_CHOOSE: begin
        d = rng_next() % 10000;
        thr = (longint'(rate) * 10000) >> 16;
        if (d < thr) begin
          r.act = 2'(rng_next() % NumActions);
          r.expl = 1'b1;
        end else begin
          r.act = greedy_action(s);
        end
      end
      tqle_pkg::FUNC_GREEDY: r.act = greedy_action(s);
      tqle_pkg::FUNC_UPDATE: begin
        q = q_table[{s, a}];
        mx = row_best(ns);
        inner = longint'(rw) * 65536 + longint'(gamma) * mx - q * 65536;
        num = q * 64'sd4294967296 + longint'(alpha) * inner;
        lim = 64'sd32767 * 64'sd4294967296;
        if (num > lim) begin
          res = 32767;
          r.sat = 1'b1;
        end else if (num < -lim) begin
          res = -32767;
          r.sat = 1'b1;
        end else begin
          mag = (num < 0) ? -num : num;
          mag = (mag + 64'h8000_0000) >> 32;
          res = (num < 0) ? -longint'(mag) : longint'(mag);
        end
        q_table[{s, a}] = res[15:0];
        r.q = res[15:0];
        step_count++;
        dec = (32'(rate) * 32'(rate_decay)) >> 16;
        rate = (dec < rate_floor) ? rate_floor : dec[15:0];
      end
      tqle_pkg::FUNC_READ: r.q = q_table[{s, a}];
      tqle_pkg::FUNC_CLEAR: wipe_table();
      default: ;
    endcase
    r.rate = rate;
    r.steps = step_count;
    return r;
  endfunction

  function automatic void apply_reg(input tqle_pkg::cfg_idx_e idx, input logic [31:0] v);
    case (idx)
      tqle_pkg::CFG_LEARN_RATE:    alpha = v[15:0];
      tqle_pkg::CFG_DISCOUNT:      gamma = v[15:0];
      tqle_pkg::CFG_EXPLORE_START: rate_start = v[15:0];
      tqle_pkg::CFG_EXPLORE_DECAY: rate_decay = v[15:0];
      tqle_pkg::CFG_EXPLORE_FLOOR: rate_floor = v[15:0];
      tqle_pkg::CFG_RANDOM_SEED:   rng_word = (v == 0) ? 32'd1 : v;
      default: ;
    endcase
  endfunction

  // receiver stall pattern and result checker
  always @(posedge clk_i) begin
    case (stall_mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom_range(0, 3) != 0);
      default: rsp.ready <= ($urandom_range(0, 9) > 6);
    endcase
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item act=%0d q=%0d", $time, rsp.chosen_action,
                 rsp.q_value);
        errors++;
      end else begin
        e = expected_results.pop_front();
        checked++;
        if (rsp.chosen_action !== e.act) begin
          $display("%0t: chosen_action exp %0d got %0d", $time, e.act, rsp.chosen_action);
          errors++;
        end
        if (rsp.explored !== e.expl) begin
          $display("%0t: explored exp %0d got %0d", $time, e.expl, rsp.explored);
          errors++;
        end
        if (rsp.q_value !== e.q) begin
          $display("%0t: q_value exp %0d got %0d", $time, e.q, rsp.q_value);
          errors++;
        end
        if (rsp.saturated !== e.sat) begin
          $display("%0t: saturated exp %0d got %0d", $time, e.sat, rsp.saturated);
          errors++;
        end
        if (rsp.explore_now !== e.rate) begin
          $display("%0t: explore_now exp %0d got %0d", $time, e.rate, rsp.explore_now);
          errors++;
        end
        if (rsp.step_total !== e.steps) begin
          $display("%0t: step_total exp %0d got %0d", $time, e.steps, rsp.step_total);
          errors++;
        end
        if (e.sat) sat_seen++;
        if (e.expl) explore_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Timeout: no item moved for %0d cycles", WatchLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] fn, input logic [5:0] s, input logic [1:0] a,
                           input logic signed [15:0] rw, input logic [5:0] ns);
    req.valid <= 1'b1;
    req.func <= fn;
    req.state_index <= s;
    req.action <= a;
    req.reward_centi <= rw;
    req.next_state <= ns;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    expected_results.push_back(engine_predict(fn, s, a, rw, ns));
  endtask

  task automatic pause_sender(input int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    pause_sender(1);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input tqle_pkg::cfg_idx_e idx, input logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(tqle_pkg::FUNC_READ, 6'd0, 2'd0, 16'sd0, 6'd0);
    send_item(tqle_pkg::FUNC_READ, 6'd63, 2'd3, 16'sh7fff, 6'd63);
    send_item(tqle_pkg::FUNC_GREEDY, 6'd7, 2'd0, 16'sd0, 6'd0);
    send_item(tqle_pkg::FUNC_CHOOSE, 6'd63, 2'd0, 16'sd0, 6'd0);
    send_item(3'd5, 6'd1, 2'd1, 16'sd5, 6'd1);
    send_item(3'd6, 6'd2, 2'd2, -16'sd5, 6'd2);
    send_item(3'd7, 6'd63, 2'd3, 16'sh7fff, 6'd63);
    send_item(tqle_pkg::FUNC_UPDATE, 6'd63, 2'd3, 16'sh7fff, 6'd0);
    send_item(tqle_pkg::FUNC_UPDATE, 6'd0, 2'd0, 16'sh8000, 6'd63);
    send_item(tqle_pkg::FUNC_GREEDY, 6'd63, 2'd0, 16'sd0, 6'd0);
    send_item(tqle_pkg::FUNC_CHOOSE, 6'd0, 2'd0, 16'sd0, 6'd0);
    drain();
    // push one cell past the positive limit and another past the negative limit
    write_reg(tqle_pkg::CFG_LEARN_RATE, 32'hffff);
    write_reg(tqle_pkg::CFG_DISCOUNT, 32'hffff);
    write_reg(tqle_pkg::CFG_EXPLORE_FLOOR, 32'h0);
    write_reg(tqle_pkg::CFG_EXPLORE_DECAY, 32'h0);
    for (int i = 0; i < 4; i++) send_item(tqle_pkg::FUNC_UPDATE, 6'd5, 2'd1, 16'sh7fff, 6'd5);
    for (int i = 0; i < 4; i++) send_item(tqle_pkg::FUNC_UPDATE, 6'd9, 2'd2, 16'sh8000, 6'd9);
    send_item(tqle_pkg::FUNC_READ, 6'd5, 2'd1, 16'sd0, 6'd0);
    send_item(tqle_pkg::FUNC_CHOOSE, 6'd5, 2'd0, 16'sd0, 6'd0);
    send_item(tqle_pkg::FUNC_CLEAR, 6'd0, 2'd0, 16'sd0, 6'd0);
    send_item(tqle_pkg::FUNC_READ, 6'd5, 2'd1, 16'sd0, 6'd0);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(tqle_pkg::CFG_RANDOM_SEED, 32'h0);
    write_reg(tqle_pkg::CFG_EXPLORE_START, 32'hffff);
    write_reg(tqle_pkg::CFG_EXPLORE_DECAY, 32'hffff);
    write_reg(tqle_pkg::CFG_EXPLORE_FLOOR, 32'hffff);
    write_reg(tqle_pkg::CFG_LEARN_RATE, 32'h0);
    write_reg(tqle_pkg::CFG_DISCOUNT, 32'h0);
    send_item(tqle_pkg::FUNC_CLEAR, 6'd0, 2'd0, 16'sd0, 6'd0);
    for (int i = 0; i < 4; i++) send_item(tqle_pkg::FUNC_CHOOSE, 6'd3, 2'd0, 16'sd0, 6'd0);
    send_item(tqle_pkg::FUNC_UPDATE, 6'd3, 2'd3, 16'sh7fff, 6'd3);
    drain();
    write_reg(tqle_pkg::CFG_RANDOM_SEED, 32'hffff_ffff);
    write_reg(tqle_pkg::CFG_EXPLORE_START, 32'h0);
    send_item(tqle_pkg::FUNC_CLEAR, 6'd0, 2'd0, 16'sd0, 6'd0);
    send_item(tqle_pkg::FUNC_CHOOSE, 6'd3, 2'd0, 16'sd0, 6'd0);
    send_item(tqle_pkg::FUNC_GREEDY, 6'd3, 2'd0, 16'sd0, 6'd0);
    drain();
  endtask

  function automatic logic [15:0] pick_q16();
    case ($urandom_range(0, 3))
      0: return 16'h0;
      1: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [5:0] pick_state();
    return ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
  endfunction

  task automatic test_random_phases(input int phases, input int per_phase);
    logic [2:0] fn;
    logic signed [15:0] rw;
    int r, left;
    for (int p = 0; p < phases; p++) begin
      write_reg(tqle_pkg::CFG_LEARN_RATE, 32'(pick_q16()));
      write_reg(tqle_pkg::CFG_DISCOUNT, 32'(pick_q16()));
      write_reg(tqle_pkg::CFG_EXPLORE_START, 32'(pick_q16()));
      write_reg(tqle_pkg::CFG_EXPLORE_DECAY,
                ($urandom_range(0, 1) != 0) ? 32'd65470 : 32'(pick_q16()));
      write_reg(tqle_pkg::CFG_EXPLORE_FLOOR,
                ($urandom_range(0, 1) != 0) ? 32'd3277 : 32'(pick_q16()));
      if ($urandom_range(0, 2) == 0) write_reg(tqle_pkg::CFG_RANDOM_SEED, $urandom());
      stall_mode = p % 3;
      gaps_on = (p % 4) != 0;
      left = $urandom_range(1, 8);
      for (int i = 0; i < per_phase; i++) begin
        r = $urandom_range(0, 99);
        if (r < 32) fn = tqle_pkg::FUNC_UPDATE;
        else if (r < 55) fn = tqle_pkg::FUNC_CHOOSE;
        else if (r < 70) fn = tqle_pkg::FUNC_GREEDY;
        else if (r < 88) fn = tqle_pkg::FUNC_READ;
        else if (r < 91) fn = tqle_pkg::FUNC_CLEAR;
        else fn = 3'($urandom_range(5, 7));
        case ($urandom_range(0, 4))
          0: rw = 16'sh7fff;
          1: rw = 16'sh8000;
          default: rw = 16'($urandom_range(0, 65535));
        endcase
        send_item(fn, pick_state(), 2'($urandom_range(0, 3)), rw, pick_state());
        if (gaps_on && --left == 0) begin
          pause_sender($urandom_range(1, 10));
          left = $urandom_range(1, 8);
        end
      end
      drain();
    end
  endtask

  initial begin
    alpha = tqle_pkg::LEARN_RATE_RST;
    gamma = tqle_pkg::DISCOUNT_RST;
    rate_start = tqle_pkg::EXPLORE_START_RST;
    rate_decay = tqle_pkg::EXPLORE_DECAY_RST;
    rate_floor = tqle_pkg::EXPLORE_FLOOR_RST;
    rng_word = tqle_pkg::RANDOM_SEED_RST;
    wipe_table();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_phases(8, 80);
    $display("Checked %0d result items: %0d saturated updates, %0d exploring choices.",
             checked, sat_seen, explore_seen);
    $display("Covered all operations, unused codes, register extremes and stall patterns.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
